/* rtl/sgr_pkg.sv */
`timescale 1ns / 1ps

package sgr_pkg;

    // Glyph geometry and default magnification limit.
    localparam int GLYPH_SIZE      = 8;
    localparam int DEF_MAX_MAGNIFY = 2;

    // Field widths.
    localparam int COORD_W  = 13;
    localparam int STRIDE_W = 15;
    localparam int OFFSET_W = 26;
    localparam int PIXEL_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Character codes at or above this limit draw nothing.
    localparam logic [7:0] CHAR_LIMIT = 8'd128;

    // Red field position for the two pixel formats.
    localparam int RED_SHIFT_565 = 11;
    localparam int RED_SHIFT_888 = 16;

    // Register reset values.
    localparam logic [COORD_W-1:0]  RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [COORD_W-1:0]  RST_SCREEN_HEIGHT = 13'd170;
    localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE   = 15'd640;
    localparam logic                RST_DEPTH_IS_32   = 1'b0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_LINE_STRIDE   = 2'd2,
        CFG_DEPTH_IS_32   = 2'd3
    } t_cfg_idx;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [COORD_W-1:0]  screen_width;
        logic [COORD_W-1:0]  screen_height;
        logic [STRIDE_W-1:0] line_stride_bytes;
        logic                depth_is_32;
    } t_cfg;

    // One glyph row request as held in the input register.
    typedef struct packed {
        logic [7:0]                char_code;
        logic [7:0]                glyph_bits;
        logic [2:0]                glyph_row;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [1:0]                magnify;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
    } t_item;

    // Per-row values shared by every write of one glyph row.
    typedef struct packed {
        logic signed [COORD_W:0] x_base;
        logic                    mag_two;
        logic [OFFSET_W-1:0]     ybase0;
        logic [OFFSET_W-1:0]     ybase1;
        logic                    depth_is_32;
        logic [PIXEL_W-1:0]      colour;
    } t_row;

endpackage

/* rtl/sgr_in_if.sv */
`timescale 1ns / 1ps

interface sgr_in_if;
    logic                                valid;
    logic                                ready;
    logic [7:0]                          char_code;
    logic [7:0]                          glyph_bits;
    logic [2:0]                          glyph_row;
    logic signed [sgr_pkg::COORD_W-1:0]  origin_x;
    logic signed [sgr_pkg::COORD_W-1:0]  origin_y;
    logic [1:0]                          magnify;
    logic [7:0]                          red;
    logic [7:0]                          green;
    logic [7:0]                          blue;

    modport source (
        output valid, char_code, glyph_bits, glyph_row, origin_x, origin_y,
               magnify, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, char_code, glyph_bits, glyph_row, origin_x, origin_y,
               magnify, red, green, blue,
        output ready
    );
endinterface

/* rtl/sgr_out_if.sv */
`timescale 1ns / 1ps

interface sgr_out_if;
    logic                          valid;
    logic                          ready;
    logic [sgr_pkg::OFFSET_W-1:0]  byte_offset;
    logic [sgr_pkg::PIXEL_W-1:0]   pixel_value;
    logic                          last_write;

    modport source (
        output valid, byte_offset, pixel_value, last_write,
        input  ready
    );
    modport sink (
        input  valid, byte_offset, pixel_value, last_write,
        output ready
    );
endinterface

/* rtl/sgr_cfg_regs.sv */
`timescale 1ns / 1ps

module sgr_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sgr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output sgr_pkg::t_cfg                     o_cfg
);

    sgr_pkg::t_cfg r_cfg;

    // Register file: each write takes the low bits that the register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width      <= sgr_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height     <= sgr_pkg::RST_SCREEN_HEIGHT;
            r_cfg.line_stride_bytes <= sgr_pkg::RST_LINE_STRIDE;
            r_cfg.depth_is_32       <= sgr_pkg::RST_DEPTH_IS_32;
        end else if (i_cfg_we) begin
            unique case (sgr_pkg::t_cfg_idx'(i_cfg_idx))
                sgr_pkg::CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[sgr_pkg::COORD_W-1:0];
                end
                sgr_pkg::CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[sgr_pkg::COORD_W-1:0];
                end
                sgr_pkg::CFG_LINE_STRIDE: begin
                    r_cfg.line_stride_bytes <= i_cfg_data[sgr_pkg::STRIDE_W-1:0];
                end
                sgr_pkg::CFG_DEPTH_IS_32: begin
                    r_cfg.depth_is_32 <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/sgr_row_prep.sv */
`timescale 1ns / 1ps

module sgr_row_prep #(
    parameter int MAX_MAGNIFY = sgr_pkg::DEF_MAX_MAGNIFY
) (
    input  sgr_pkg::t_item                                      i_item,
    input  sgr_pkg::t_cfg                                       i_cfg,
    output logic [sgr_pkg::GLYPH_SIZE*MAX_MAGNIFY*MAX_MAGNIFY-1:0] o_mask,
    output sgr_pkg::t_row                                       o_row
);

    localparam int SUB   = MAX_MAGNIFY * MAX_MAGNIFY;
    localparam int SLOTS = sgr_pkg::GLYPH_SIZE * SUB;
    localparam int CW    = sgr_pkg::COORD_W;

    logic                   mag_two;
    logic                   char_ok;
    logic [3:0]             row_off;
    logic signed [CW:0]     x_base;
    logic signed [CW:0]     y0;
    logic signed [CW+16:0]  y_prod;
    logic [MAX_MAGNIFY-1:0] row_ok;
    logic [sgr_pkg::PIXEL_W-1:0] colour;

    // Magnify of 0 acts as 1; anything above the limit acts as the limit.
    assign mag_two = (MAX_MAGNIFY > 1) && i_item.magnify[1];
    assign char_ok = i_item.char_code < sgr_pkg::CHAR_LIMIT;

    // First screen line covered by this glyph row, and its byte base.
    assign row_off = mag_two ? {i_item.glyph_row, 1'b0} : {1'b0, i_item.glyph_row};
    assign x_base  = (CW+1)'(i_item.origin_x);
    assign y0      = (CW+1)'(i_item.origin_y) + (CW+1)'(row_off);
    assign y_prod  = y0 * $signed({1'b0, i_cfg.line_stride_bytes});

    // Vertical clip for each sub-row.
    for (genvar s = 0; s < MAX_MAGNIFY; s++) begin : g_row
        logic [CW:0] y_s;
        assign y_s       = y0 + (CW+1)'(s);
        assign row_ok[s] = !y_s[CW] && (y_s[CW-1:0] < i_cfg.screen_height);
    end

    // One slot per column, sub-row and sub-column, in output order.
    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        localparam int COL = k / SUB;
        localparam int SY  = (k / MAX_MAGNIFY) % MAX_MAGNIFY;
        localparam int SX  = k % MAX_MAGNIFY;
        logic [CW:0] x_k;
        logic        used;
        assign x_k  = x_base + (mag_two ? (CW+1)'(2 * COL) : (CW+1)'(COL))
                      + (CW+1)'(SX);
        assign used = ((SY == 0) || mag_two) && ((SX == 0) || mag_two);
        assign o_mask[k] = char_ok && used && i_item.glyph_bits[COL] && row_ok[SY]
                           && !x_k[CW] && (x_k[CW-1:0] < i_cfg.screen_width);
    end

    // Colour packing for the selected pixel depth.
    always_comb begin
        if (i_cfg.depth_is_32) begin
            colour = (24'(i_item.red) << sgr_pkg::RED_SHIFT_888)
                   | (24'(i_item.green) << 8) | 24'(i_item.blue);
        end else begin
            colour = (24'(i_item.red[7:3]) << sgr_pkg::RED_SHIFT_565)
                   | (24'(i_item.green[7:2]) << 5) | 24'(i_item.blue[7:3]);
        end
    end

    assign o_row.x_base      = x_base;
    assign o_row.mag_two     = mag_two;
    assign o_row.ybase0      = y_prod[sgr_pkg::OFFSET_W-1:0];
    assign o_row.ybase1      = y_prod[sgr_pkg::OFFSET_W-1:0]
                               + sgr_pkg::OFFSET_W'(i_cfg.line_stride_bytes);
    assign o_row.depth_is_32 = i_cfg.depth_is_32;
    assign o_row.colour      = colour;

endmodule

/* rtl/sgr_walker.sv */
`timescale 1ns / 1ps

module sgr_walker #(
    parameter int MAX_MAGNIFY = sgr_pkg::DEF_MAX_MAGNIFY
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_load,
    input  logic [sgr_pkg::GLYPH_SIZE*MAX_MAGNIFY*MAX_MAGNIFY-1:0] i_mask,
    input  sgr_pkg::t_row                                       i_row,
    output logic                                                o_free,
    sgr_out_if.source                                           o_write
);

    localparam int SUB   = MAX_MAGNIFY * MAX_MAGNIFY;
    localparam int SLOTS = sgr_pkg::GLYPH_SIZE * SUB;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CW    = sgr_pkg::COORD_W;

    logic [SLOTS-1:0]            r_mask;
    logic [SLOTS-1:0]            n_mask;
    sgr_pkg::t_row               r_row;
    logic                        r_o_valid;
    logic [sgr_pkg::OFFSET_W-1:0] r_offset;
    logic [sgr_pkg::PIXEL_W-1:0]  r_pixel;
    logic                        r_last;

    logic                        out_free;
    logic                        emit;
    logic [SLOTS-1:0]            onehot;
    logic [SLOTS-1:0]            rest;
    logic                        last;
    logic [IDX_W-1:0]            sel;
    logic [2:0]                  col;
    logic                        sy_odd;
    logic                        sx_one;
    logic [CW:0]                 x;
    logic [sgr_pkg::OFFSET_W-1:0] off;

    // Pick the lowest pending slot.
    assign out_free = !r_o_valid || o_write.ready;
    assign emit     = (|r_mask) && out_free;
    assign onehot   = r_mask & (~r_mask + SLOTS'(1));
    assign rest     = r_mask & ~onehot;
    assign last     = rest == '0;
    assign o_free   = (r_mask == '0) || (emit && last);

    always_comb begin
        sel = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (onehot[i]) begin
                sel = sel | IDX_W'(i);
            end
        end
    end

    // Screen position and byte offset of the selected slot.
    assign col    = 3'(32'(sel) / SUB);
    assign sy_odd = ((32'(sel) / MAX_MAGNIFY) % MAX_MAGNIFY) != 0;
    assign sx_one = (32'(sel) % MAX_MAGNIFY) != 0;
    assign x      = r_row.x_base + (r_row.mag_two ? (CW+1)'({col, 1'b0}) : (CW+1)'(col))
                    + (CW+1)'(sx_one);

    always_comb begin
        if (r_row.depth_is_32) begin
            off = (sy_odd ? r_row.ybase1 : r_row.ybase0)
                + (sgr_pkg::OFFSET_W'(x[CW-1:0]) << 2);
        end else begin
            off = (sy_odd ? r_row.ybase1 : r_row.ybase0)
                + (sgr_pkg::OFFSET_W'(x[CW-1:0]) << 1);
        end
    end

    // Pending slot mask: a new row takes over once the current one is spent.
    always_comb begin
        if (i_load && o_free) begin
            n_mask = i_mask;
        end else if (emit) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_row <= i_row;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (o_write.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_offset <= off;
            r_pixel  <= r_row.colour;
            r_last   <= last;
        end
    end

    assign o_write.valid       = r_o_valid;
    assign o_write.byte_offset = r_offset;
    assign o_write.pixel_value = r_pixel;
    assign o_write.last_write  = r_last;

    // A stalled output freezes the pending slots of a row in progress.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_write.ready && (r_mask != '0)) |=> $stable(r_mask))
        else $error("pending slots changed while the output was stalled");

    // Each beat retires exactly one slot of the current row.
    a_one_per_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> ($countones(r_mask) == $past($countones(r_mask)) - 1))
        else $error("a beat retired other than one slot");

    // Pending work with a free output always produces a beat.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mask != '0) && !r_o_valid) |=> r_o_valid)
        else $error("walker idled with pending slots");

    // The slot selector names exactly one slot whenever work is pending.
    a_single_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) |-> $onehot(onehot))
        else $error("slot selector is not one-hot");

endmodule

/* rtl/scaled_glyph_row_rasterizer_core.sv */
`timescale 1ns / 1ps

// Scaled glyph row rasterizer.
// The i_glyph channel takes one glyph row per beat: its bit pattern, the row
// index, the glyph origin, a magnification of 1 or 2 and the drawing colour.
// The o_write channel gives one framebuffer write per beat: byte offset,
// packed colour and a flag on the last write of that glyph row. Writes come
// in column, sub-row, sub-column order; clipped pixels and character codes of
// 128 or more give no writes, and a row that is clipped entirely gives none.
// A row's first write passes the input register, the walker's slot mask and
// the output register. The write walker emits one write per cycle unless the
// receiver stalls; a row has at most 32 writes at magnification 2, and rows
// without writes pass at one per cycle while the walker is free. A new row
// is taken into an input register while the previous one is being walked.
// When the receiver stalls, the output register holds its write, the walker
// waits and the input register fills, after which i_glyph.ready drops.
// The configuration port writes one register per cycle with i_cfg_we and
// should only be used while no row is in flight. Synchronous reset restores
// the register defaults (320 x 170, stride 640, 16 bits per pixel) and
// empties the pipeline.

module scaled_glyph_row_rasterizer_core #(
    parameter int MAX_MAGNIFY = sgr_pkg::DEF_MAX_MAGNIFY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sgr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sgr_in_if.sink                          i_glyph,
    sgr_out_if.source                       o_write
);

    localparam int SLOTS = sgr_pkg::GLYPH_SIZE * MAX_MAGNIFY * MAX_MAGNIFY;

    sgr_pkg::t_cfg    cfg;
    sgr_pkg::t_item   r_in;
    logic             r_in_valid;
    logic             n_in_valid;
    logic             accept;
    logic             w_free;
    logic             w_load;
    logic [SLOTS-1:0] mask;
    sgr_pkg::t_row    row;

    sgr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Input register: refilled in the same cycle the walker takes its row.
    assign w_load        = r_in_valid && w_free;
    assign i_glyph.ready = !r_in_valid || w_free;
    assign accept        = i_glyph.valid && i_glyph.ready;

    always_comb begin
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (w_load) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.char_code  <= i_glyph.char_code;
            r_in.glyph_bits <= i_glyph.glyph_bits;
            r_in.glyph_row  <= i_glyph.glyph_row;
            r_in.origin_x   <= i_glyph.origin_x;
            r_in.origin_y   <= i_glyph.origin_y;
            r_in.magnify    <= i_glyph.magnify;
            r_in.red        <= i_glyph.red;
            r_in.green      <= i_glyph.green;
            r_in.blue       <= i_glyph.blue;
        end
    end

    sgr_row_prep #(
        .MAX_MAGNIFY (MAX_MAGNIFY)
    ) u_prep (
        .i_item (r_in),
        .i_cfg  (cfg),
        .o_mask (mask),
        .o_row  (row)
    );

    sgr_walker #(
        .MAX_MAGNIFY (MAX_MAGNIFY)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid),
        .i_mask  (mask),
        .i_row   (row),
        .o_free  (w_free),
        .o_write (o_write)
    );

endmodule
